// ===== src/lss_pkg.sv =====
// Package with the shared constants and types of the longest subarray block.
`timescale 1ns / 1ps
`default_nettype none

package lss_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int SUM_OFFSET   = 2048;
    localparam int TABLE_DEPTH  = 4096;
    localparam int ADDR_W       = $clog2(TABLE_DEPTH);
    localparam int VAL_W        = 16;
    localparam int SUM_W        = 27;
    localparam int IDX_W        = SUM_W + 2;
    localparam int LEN_W        = 11;
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int EPOCH_W      = 8;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

    localparam bit SEED_IN = (SUM_OFFSET >= 0) && (SUM_OFFSET < TABLE_DEPTH);

    typedef logic signed [VAL_W-1:0] value_t;
    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic signed [IDX_W-1:0] idx_t;
    typedef logic [ADDR_W-1:0]       addr_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic [LEN_W-1:0]        len_t;
    typedef logic [EPOCH_W-1:0]      epoch_t;

    localparam addr_t  SEED_ADDR  = ADDR_W'(SUM_OFFSET);
    localparam idx_t   OFFSET_IDX = IDX_W'(SUM_OFFSET);
    localparam epoch_t EPOCH_NONE = '0;
    localparam epoch_t EPOCH_LAST = '1;
    localparam epoch_t EPOCH_INIT = EPOCH_W'(1);

    typedef struct packed {
        epoch_t epoch;
        cnt_t   pos;
    } entry_t;

    typedef struct packed {
        logic   en;
        addr_t  addr;
        entry_t data;
    } tbl_wr_t;

    typedef struct packed {
        len_t max_length;
        logic too_long;
    } result_t;

endpackage : lss_pkg

`default_nettype wire

// ===== src/lss_ifs.sv =====
// Handshake interfaces for the element, configuration and result channels.
`timescale 1ns / 1ps
`default_nettype none

interface lss_elem_if;
    logic            valid;
    logic            ready;
    lss_pkg::value_t value;
    logic            last;

    modport source (output valid, output value, output last, input ready);
    modport sink (input valid, input value, input last, output ready);
endinterface : lss_elem_if

interface lss_cfg_if;
    logic          valid;
    logic          ready;
    lss_pkg::sum_t target_sum;

    modport source (output valid, output target_sum, input ready);
    modport sink (input valid, input target_sum, output ready);
endinterface : lss_cfg_if

interface lss_result_if;
    logic          valid;
    logic          ready;
    lss_pkg::len_t max_length;
    logic          too_long;

    modport source (output valid, output max_length, output too_long, input ready);
    modport sink (input valid, input max_length, input too_long, output ready);
endinterface : lss_result_if

`default_nettype wire

// ===== src/lss_table.sv =====
// Prefix sum table: one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module lss_table (
    input  wire                    clk,
    input  wire                    rd_en,
    input  wire  lss_pkg::addr_t   rd_addr_a,
    input  wire  lss_pkg::addr_t   rd_addr_b,
    output lss_pkg::entry_t        rd_data_a,
    output lss_pkg::entry_t        rd_data_b,
    input  wire  lss_pkg::tbl_wr_t wr
);
    import lss_pkg::*;

    entry_t mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule : lss_table

`default_nettype wire

// ===== src/lss_result_fifo.sv =====
// Small result queue that drives the result channel.
`timescale 1ns / 1ps
`default_nettype none

module lss_result_fifo (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     push,
    input  wire  lss_pkg::result_t  push_data,
    output logic [lss_pkg::FIFO_CNT_W-1:0] count,
    lss_result_if.source            result
);
    import lss_pkg::*;

    result_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  pop;

    assign pop               = result.valid && result.ready;
    assign result.valid      = (cnt_reg != '0);
    assign result.max_length = mem_reg[rd_ptr_reg].max_length;
    assign result.too_long   = mem_reg[rd_ptr_reg].too_long;
    assign count             = cnt_reg;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + FIFO_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + FIFO_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule : lss_result_fifo

`default_nettype wire

// ===== src/longest_subarray_with_sum.sv =====
// Top level of the longest subarray with a given sum block.
// Throughput: one item per cycle while elem.ready is high; table ports serve one per cycle.
// A result passes p0_reg, p1_reg and the result queue before it is offered.
// Reset: target sum 0, array state cleared, then a clearing pass over all 4096 table entries.
// The same clearing pass runs again after every 255th array, when the table epoch wraps.
// Configuration writes are taken at all times, including during a clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module longest_subarray_with_sum (
    input  wire          clk,
    input  wire          rst_n,
    lss_elem_if.sink     elem,
    lss_cfg_if.sink      cfg,
    lss_result_if.source result
);
    import lss_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    typedef struct packed {
        sum_t   sum;
        cnt_t   cnt;
        epoch_t epoch;
        logic   last;
        logic   upd;
        logic   ovf;
    } p0_t;

    typedef struct packed {
        cnt_t   cnt;
        epoch_t epoch;
        logic   last;
        logic   upd;
        logic   ovf;
        logic   in_sum;
        addr_t  sum_addr;
        logic   in_diff;
        addr_t  diff_addr;
    } p1_t;

    state_t  st_reg, st_next;
    addr_t   clr_reg, clr_next;
    epoch_t  epoch_reg, epoch_next;
    sum_t    sum_reg, sum_next;
    cnt_t    count_reg, count_next;
    logic    ovf_reg, ovf_next;
    idx_t    toff_reg, toff_next;
    cnt_t    best_reg, best_next;
    logic    p0_valid_reg, p1_valid_reg;
    p0_t     p0_reg, p0_next;
    p1_t     p1_reg, p1_next;
    logic    wr_prev_valid_reg;
    addr_t   wr_prev_addr_reg;
    entry_t  wr_prev_data_reg;

    logic                  in_fire;
    logic                  upd_now;
    sum_t                  sum_add;
    logic [FIFO_CNT_W:0]   pend;
    logic [FIFO_CNT_W-1:0] fifo_cnt;
    idx_t                  sum_wide;
    idx_t                  sum_idx;
    idx_t                  diff_idx;
    entry_t                rd_s, rd_d;
    entry_t                ent_s, ent_d;
    logic                  seed_s, seed_d;
    logic                  known_s, hit_d;
    cnt_t                  pos_d, len_d;
    cnt_t                  best_cand;
    logic                  do_upd;
    logic                  pipe_wr;
    tbl_wr_t               tbl_wr;
    logic                  push;
    result_t               push_data;

    // Accept side: running sum, element count, overflow flag, target offset and the clearing state machine.
    assign pend = (FIFO_CNT_W + 1)'(fifo_cnt)
                + (FIFO_CNT_W + 1)'(p0_valid_reg && p0_reg.last)
                + (FIFO_CNT_W + 1)'(p1_valid_reg && p1_reg.last);

    assign elem.ready = (st_reg == ST_RUN) && (pend < (FIFO_CNT_W + 1)'(FIFO_DEPTH));
    assign cfg.ready  = 1'b1;
    assign in_fire    = elem.valid && elem.ready;
    assign upd_now    = (count_reg < CNT_W'(MAX_ELEMENTS));
    assign sum_add    = sum_reg + SUM_W'(elem.value);

    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        epoch_next = epoch_reg;
        toff_next  = toff_reg;
        st_next    = st_reg;
        clr_next   = clr_reg;

        p0_next.sum   = upd_now ? sum_add : sum_reg;
        p0_next.cnt   = count_reg + CNT_W'(1);
        p0_next.epoch = epoch_reg;
        p0_next.last  = elem.last;
        p0_next.upd   = upd_now;
        p0_next.ovf   = ovf_reg || !upd_now;

        if (cfg.valid && cfg.ready)
        begin
            toff_next = OFFSET_IDX - IDX_W'(cfg.target_sum);
        end

        if (in_fire)
        begin
            if (elem.last)
            begin
                sum_next   = '0;
                count_next = '0;
                ovf_next   = 1'b0;
                if (epoch_reg == EPOCH_LAST)
                begin
                    epoch_next = EPOCH_INIT;
                end
                else
                begin
                    epoch_next = epoch_reg + EPOCH_W'(1);
                end
            end
            else
            begin
                sum_next   = p0_next.sum;
                count_next = upd_now ? p0_next.cnt : count_reg;
                ovf_next   = p0_next.ovf;
            end
        end

        case (st_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(TABLE_DEPTH - 1))
                begin
                    st_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (in_fire && elem.last && (epoch_reg == EPOCH_LAST))
                begin
                    st_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                clr_next = '0;
                if (!p0_valid_reg && !p1_valid_reg)
                begin
                    st_next = ST_CLEAR;
                end
            end
            default:
            begin
                st_next = ST_CLEAR;
                clr_next = '0;
            end
        endcase
    end

    // Stage one: table addresses for the current sum and for the sum minus the target.
    assign sum_wide = IDX_W'(p0_reg.sum);
    assign sum_idx  = sum_wide + OFFSET_IDX;
    assign diff_idx = sum_wide + toff_reg;

    always_comb
    begin
        p1_next.cnt       = p0_reg.cnt;
        p1_next.epoch     = p0_reg.epoch;
        p1_next.last      = p0_reg.last;
        p1_next.upd       = p0_reg.upd;
        p1_next.ovf       = p0_reg.ovf;
        p1_next.in_sum    = (sum_idx[IDX_W-1:ADDR_W] == '0);
        p1_next.sum_addr  = sum_idx[ADDR_W-1:0];
        p1_next.in_diff   = (diff_idx[IDX_W-1:ADDR_W] == '0);
        p1_next.diff_addr = diff_idx[ADDR_W-1:0];
    end

    lss_table u_table (
        .clk       (clk),
        .rd_en     (p0_valid_reg),
        .rd_addr_a (p1_next.sum_addr),
        .rd_addr_b (p1_next.diff_addr),
        .rd_data_a (rd_s),
        .rd_data_b (rd_d),
        .wr        (tbl_wr)
    );

    // Stage two: resolve the lookups, with the write of the previous cycle forwarded.
    always_comb
    begin
        ent_s = (wr_prev_valid_reg && (wr_prev_addr_reg == p1_reg.sum_addr))
              ? wr_prev_data_reg : rd_s;
        ent_d = (wr_prev_valid_reg && (wr_prev_addr_reg == p1_reg.diff_addr))
              ? wr_prev_data_reg : rd_d;

        seed_s  = SEED_IN && (p1_reg.sum_addr == SEED_ADDR);
        seed_d  = SEED_IN && (p1_reg.diff_addr == SEED_ADDR);
        known_s = seed_s || (ent_s.epoch == p1_reg.epoch);
        hit_d   = p1_reg.in_diff && (seed_d || (ent_d.epoch == p1_reg.epoch));
        pos_d   = seed_d ? '0 : ent_d.pos;
        len_d   = p1_reg.cnt - pos_d;

        do_upd    = p1_valid_reg && p1_reg.upd;
        best_cand = (do_upd && hit_d && (len_d > best_reg)) ? len_d : best_reg;
        pipe_wr   = do_upd && p1_reg.in_sum && !known_s;

        if (st_reg == ST_CLEAR)
        begin
            tbl_wr.en         = 1'b1;
            tbl_wr.addr       = clr_reg;
            tbl_wr.data.epoch = EPOCH_NONE;
            tbl_wr.data.pos   = '0;
        end
        else
        begin
            tbl_wr.en         = pipe_wr;
            tbl_wr.addr       = p1_reg.sum_addr;
            tbl_wr.data.epoch = p1_reg.epoch;
            tbl_wr.data.pos   = p1_reg.cnt;
        end

        push                 = p1_valid_reg && p1_reg.last;
        push_data.max_length = LEN_W'(best_cand);
        push_data.too_long   = p1_reg.ovf;

        if (push)
        begin
            best_next = '0;
        end
        else
        begin
            best_next = best_cand;
        end
    end

    lss_result_fifo u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .count     (fifo_cnt),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg            <= ST_CLEAR;
            clr_reg           <= '0;
            epoch_reg         <= EPOCH_INIT;
            sum_reg           <= '0;
            count_reg         <= '0;
            ovf_reg           <= 1'b0;
            toff_reg          <= OFFSET_IDX;
            best_reg          <= '0;
            p0_valid_reg      <= 1'b0;
            p1_valid_reg      <= 1'b0;
            wr_prev_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg            <= st_next;
            clr_reg           <= clr_next;
            epoch_reg         <= epoch_next;
            sum_reg           <= sum_next;
            count_reg         <= count_next;
            ovf_reg           <= ovf_next;
            toff_reg          <= toff_next;
            best_reg          <= best_next;
            p0_valid_reg      <= in_fire;
            p1_valid_reg      <= p0_valid_reg;
            wr_prev_valid_reg <= pipe_wr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            p0_reg <= p0_next;
        end
        if (p0_valid_reg)
        begin
            p1_reg <= p1_next;
        end
        wr_prev_addr_reg <= p1_reg.sum_addr;
        wr_prev_data_reg <= tbl_wr.data;
    end

    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_CLEAR) |-> (!p0_valid_reg && !p1_valid_reg))
        else $error("Table clearing pass overlaps an item in flight.");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend <= (FIFO_CNT_W + 1)'(FIFO_DEPTH))
        else $error("More results pending than the result queue holds.");

    a_seed_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (pipe_wr && SEED_IN) |-> (p1_reg.sum_addr != SEED_ADDR))
        else $error("The zero-sum seed entry was overwritten.");

    a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
        (!p1_valid_reg || (p1_reg.epoch != EPOCH_NONE)) && (epoch_reg != EPOCH_NONE))
        else $error("An item carries the empty epoch mark.");

endmodule : longest_subarray_with_sum

`default_nettype wire

// ===== bench/tb_longest_subarray_with_sum.sv =====
// Self-checking testbench that drives arrays into the longest subarray block and checks each length and overflow flag.
`timescale 1ns / 1ps

module tb_longest_subarray_with_sum;
    import lss_pkg::*;

    localparam int STALL_LIMIT = 5 * TABLE_DEPTH;

    logic clk;
    logic rst_n;
    logic steady;
    int   failures;
    int   stall_cycles;

    lss_elem_if   elem_bus ();
    lss_cfg_if    cfg_bus ();
    lss_result_if res_bus ();

    longest_subarray_with_sum i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .elem   (elem_bus),
        .cfg    (cfg_bus),
        .result (res_bus)
    );

    sum_t    target;
    sum_t    prefix_sum;
    int      taken_count;
    int      longest_run;
    logic    overflowed;
    bit      sum_seen [TABLE_DEPTH];
    int      sum_first_pos [TABLE_DEPTH];
    result_t pending_results [$];

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic void restart_array();
        prefix_sum  = '0;
        taken_count = 0;
        longest_run = 0;
        overflowed  = 1'b0;
        foreach (sum_seen[i])
        begin
            sum_seen[i] = 1'b0;
        end
        if (SUM_OFFSET >= 0 && SUM_OFFSET < TABLE_DEPTH)
        begin
            sum_seen[SUM_OFFSET]      = 1'b1;
            sum_first_pos[SUM_OFFSET] = 0;
        end
    endfunction

    function automatic void track_element(input value_t v, input logic l);
        longint slot;
        result_t outcome;
        if (taken_count >= MAX_ELEMENTS)
        begin
            overflowed = 1'b1;
        end
        else
        begin
            prefix_sum = prefix_sum + sum_t'(v);
            taken_count++;
            slot = longint'(prefix_sum) - longint'(target) + SUM_OFFSET;
            if (slot >= 0 && slot < TABLE_DEPTH)
            begin
                if (sum_seen[slot] && taken_count - sum_first_pos[slot] > longest_run)
                begin
                    longest_run = taken_count - sum_first_pos[slot];
                end
            end
            slot = longint'(prefix_sum) + SUM_OFFSET;
            if (slot >= 0 && slot < TABLE_DEPTH)
            begin
                if (!sum_seen[slot])
                begin
                    sum_seen[slot]      = 1'b1;
                    sum_first_pos[slot] = taken_count;
                end
            end
        end
        if (l)
        begin
            outcome.max_length = len_t'(longest_run);
            outcome.too_long   = overflowed;
            pending_results.push_back(outcome);
            restart_array();
        end
    endfunction

    function automatic value_t pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 80)
        begin
            return value_t'(int'($urandom_range(0, 10)) - 5);
        end
        else if (r < 97)
        begin
            return value_t'(int'($urandom_range(0, 600)) - 300);
        end
        return value_t'($urandom);
    endfunction

    task automatic send_element(input value_t v, input logic l);
        if (!steady && $urandom_range(99) < 7)
        begin
            elem_bus.valid <= 1'b0;
            @(negedge clk);
        end
        elem_bus.valid <= 1'b1;
        elem_bus.value <= v;
        elem_bus.last  <= l;
        @(posedge clk);
        while (!elem_bus.ready)
        begin
            @(posedge clk);
        end
        track_element(v, l);
        @(negedge clk);
    endtask

    task automatic drain_results();
        elem_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic set_target(input sum_t t);
        cfg_bus.valid      <= 1'b1;
        cfg_bus.target_sum <= t;
        @(posedge clk);
        while (!cfg_bus.ready)
        begin
            @(posedge clk);
        end
        target = t;
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic test_short_arrays();
        set_target(sum_t'(5));
        send_element(value_t'(5), 1'b1);
        send_element(value_t'(4), 1'b1);
        send_element(value_t'(-3), 1'b0);
        send_element(value_t'(8), 1'b1);
        drain_results();
        set_target(sum_t'(3));
        send_element(value_t'(1), 1'b0);
        send_element(value_t'(1), 1'b1);
        drain_results();
    endtask

    task automatic test_value_extremes();
        set_target(sum_t'(0));
        send_element(value_t'(32767), 1'b0);
        send_element(value_t'(-32768), 1'b0);
        send_element(value_t'(1), 1'b1);
        send_element(value_t'(-32768), 1'b1);
        send_element(value_t'(32767), 1'b1);
        drain_results();
    endtask

    task automatic test_table_edges();
        send_element(value_t'(2047), 1'b0);
        send_element(value_t'(1), 1'b0);
        send_element(value_t'(-1), 1'b1);
        send_element(value_t'(-2048), 1'b0);
        send_element(value_t'(-1), 1'b0);
        send_element(value_t'(1), 1'b1);
        drain_results();
    endtask

    task automatic test_overflow();
        int i;
        steady = 1'b1;
        for (i = 0; i < MAX_ELEMENTS + 2; i++)
        begin
            send_element(value_t'(int'($urandom_range(0, 2)) - 1), i == MAX_ELEMENTS + 1);
        end
        steady = 1'b0;
        drain_results();
    endtask

    task automatic send_random_arrays(input int budget, input int max_len);
        int  sent;
        int  len;
        int  i;
        bit  noisy;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(99) < 85)
            begin
                len = $urandom_range(1, max_len);
            end
            else
            begin
                len = $urandom_range(1, 6 * max_len);
            end
            noisy = $urandom_range(99) < 10;
            for (i = 0; i < len; i++)
            begin
                send_element(noisy ? value_t'($urandom) : pick_value(), i == len - 1);
            end
            sent += len;
        end
        drain_results();
    endtask

    task automatic test_random_arrays();
        int k;
        for (k = 0; k < 8; k++)
        begin
            case (k)
                0: set_target(sum_t'(0));
                4: set_target(sum_t'(67108863));
                6: set_target(sum_t'($urandom));
                7: set_target(sum_t'(-67108864));
                default: set_target(sum_t'(int'($urandom_range(0, 16)) - 8));
            endcase
            steady = (k == 3);
            if (k == 2)
            begin
                send_random_arrays(40, 2);
            end
            else if (k == 4 || k == 7)
            begin
                send_random_arrays(10, 10);
            end
            else
            begin
                send_random_arrays(20, 10);
            end
        end
        steady = 1'b0;
    endtask

    always @(negedge clk)
    begin
        res_bus.ready <= steady || ($urandom_range(99) >= 7);
    end

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: max_length %0d too_long %0b",
                       res_bus.max_length, res_bus.too_long);
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (res_bus.max_length !== want.max_length)
                begin
                    $error("max_length: expected %0d, got %0d",
                           want.max_length, res_bus.max_length);
                    failures++;
                end
                if (res_bus.too_long !== want.too_long)
                begin
                    $error("too_long: expected %0b, got %0b",
                           want.too_long, res_bus.too_long);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (elem_bus.valid && elem_bus.ready) || (cfg_bus.valid && cfg_bus.ready)
            || (res_bus.valid && res_bus.ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no item moved for %0d cycles.", STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        steady             = 1'b0;
        failures           = 0;
        stall_cycles       = 0;
        elem_bus.valid     = 1'b0;
        elem_bus.value     = '0;
        elem_bus.last      = 1'b0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.target_sum = '0;
        res_bus.ready      = 1'b0;
        target             = '0;
        restart_array();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_short_arrays();
        test_value_extremes();
        test_table_edges();
        test_overflow();
        test_random_arrays();
        repeat (8) @(posedge clk);
        if (failures == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule : tb_longest_subarray_with_sum
